/* sv/rv32_pkg.sv */
// Shared constants, types and helpers for the RV32I subset executor.
package rv32_pkg;

    localparam int MEM_WORDS_DEF = 4096;

    localparam logic [2:0] OP_MEM_WRITE = 3'd0;
    localparam logic [2:0] OP_MEM_READ  = 3'd1;
    localparam logic [2:0] OP_REG_READ  = 3'd2;
    localparam logic [2:0] OP_SET_PC    = 3'd3;
    localparam logic [2:0] OP_EXEC      = 3'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_ILLEGAL   = 3'd1;
    localparam logic [2:0] ST_X0        = 3'd2;
    localparam logic [2:0] ST_RANGE     = 3'd3;
    localparam logic [2:0] ST_MISALIGN  = 3'd4;

    localparam logic [6:0] OPC_ALU_REG  = 7'b0110011;
    localparam logic [6:0] OPC_ALU_IMM  = 7'b0010011;
    localparam logic [6:0] OPC_LOAD     = 7'b0000011;
    localparam logic [6:0] OPC_JALR     = 7'b1100111;
    localparam logic [6:0] OPC_STORE    = 7'b0100011;
    localparam logic [6:0] F7_ALT       = 7'h20;
    localparam logic [35:0] BYTE_ADDR_LIMIT = 36'h3ffffffff;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] read_data;
        logic        reg_written;
        logic [4:0]  reg_dest;
        logic [31:0] reg_value;
    } result_t;

    function automatic logic [31:0] alu(input logic [2:0] f3, input logic alt,
                                        input logic [31:0] a, input logic [31:0] b);
        logic [31:0] r;
        case (f3)
            3'd0: r = alt ? a - b : a + b;
            3'd1: r = a << b[4:0];
            3'd2: r = {31'd0, $signed(a) < $signed(b)};
            3'd3: r = {31'd0, a < b};
            3'd4: r = a ^ b;
            3'd5: r = alt ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
            3'd6: r = a | b;
            default: r = a & b;
        endcase
        return r;
    endfunction

endpackage

/* sv/rv32_core.sv */
// Multicycle sequencer: fetch, register read, execute/memory, write back.
module rv32_core
    import rv32_pkg::*;
#(
    parameter int MEM_WORDS = MEM_WORDS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  op,
    input  logic [13:0] address,
    input  logic [4:0]  reg_index,
    input  logic [31:0] data,
    output logic        out_valid,
    input  logic        out_ready,
    output result_t     res,
    output logic [14:0] pc
);
    localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
    localparam int CLR_LEN = (MEM_WORDS > 32) ? MEM_WORDS : 32;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_HOST  = 4'd2;
    localparam logic [3:0] S_FETCH = 4'd3;
    localparam logic [3:0] S_DEC   = 4'd4;
    localparam logic [3:0] S_EXEC  = 4'd5;
    localparam logic [3:0] S_MEM   = 4'd6;
    localparam logic [3:0] S_OUT   = 4'd7;
    localparam logic [3:0] S_ADDR  = 4'd8;

    logic [31:0] mem [MEM_WORDS];
    logic [31:0] rf  [32];

    logic [3:0]  state_reg, state_next;
    logic [AW:0] clr_reg;
    logic [14:0] pc_reg;
    logic [2:0]  op_reg;
    logic [13:0] addr_reg;
    logic [31:0] data_reg;
    logic [31:0] ins_reg;
    logic [31:0] a_reg, b_reg;
    logic [31:0] mrd_reg;
    logic [31:0] rrd_reg;
    logic [35:0] ba_reg;
    logic [2:0]  bst_reg;
    result_t     res_reg;

    logic          mem_we;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [31:0]   mem_wd;
    logic          rf_we;
    logic [4:0]    rf_wa;
    logic [31:0]   rf_wd;

    logic [6:0]  opc;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] imm_i, imm_s, imm;
    logic [1:0]  size_log;
    logic [35:0] ba;
    logic [1:0]  koff;
    logic [33:0] jt;

    assign opc   = ins_reg[6:0];
    assign rd    = ins_reg[11:7];
    assign f3    = ins_reg[14:12];
    assign f7    = ins_reg[31:25];
    assign imm_i = {{20{ins_reg[31]}}, ins_reg[31:20]};
    assign imm_s = {{20{ins_reg[31]}}, ins_reg[31:25], ins_reg[11:7]};
    assign imm   = (opc == OPC_STORE) ? imm_s : imm_i;
    assign size_log = (f3[1:0] == 2'd0) ? 2'd0 : ((f3[1:0] == 2'd1) ? 2'd1 : 2'd2);
    assign ba    = $signed({2'b00, a_reg, 2'b00})
                 + ($signed({{4{imm[31]}}, imm}) <<< size_log);
    assign koff  = ba_reg[1:0];
    assign jt    = $signed({2'b00, a_reg}) + $signed({{2{imm_i[31]}}, imm_i});

    always_comb
    begin
        mem_ra = AW'(pc_reg[14:2]);
        if (state_reg == S_IDLE && op != OP_EXEC)
            mem_ra = AW'(address[13:2]);
        else if (state_reg == S_ADDR)
            mem_ra = AW'(ba[35:2]);
    end

    // memory and register file
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        mrd_reg <= mem[mem_ra];
        if (rf_we)
            rf[rf_wa] <= rf_wd;
        if (state_reg == S_DEC)
        begin
            a_reg <= rf[mrd_reg[19:15]];
            b_reg <= rf[mrd_reg[24:20]];
        end
        rrd_reg <= rf[reg_index];
    end

    logic host_bad_align, host_bad_range;
    assign host_bad_align = addr_reg[1:0] != 2'd0;
    assign host_bad_range = (32'(addr_reg[13:2]) >= 32'(MEM_WORDS));

    logic [31:0] ld_val, st_word, st_mask;
    logic [4:0]  shamt;
    always_comb
    begin
        shamt  = 5'(5'd24 - {koff, 3'd0});
        ld_val = mrd_reg;
        st_mask = 32'hffffffff;
        st_word = b_reg;
        if (size_log == 2'd0)
        begin
            ld_val = (mrd_reg >> shamt) & 32'hff;
            if (!f3[2] && ld_val[7])
                ld_val = ld_val | 32'hffffff00;
            st_mask = 32'hff << shamt;
            st_word = b_reg << shamt;
        end
        else if (size_log == 2'd1)
        begin
            shamt  = 5'(5'd16 - {koff, 3'd0});
            ld_val = (mrd_reg >> shamt) & 32'hffff;
            if (!f3[2] && ld_val[15])
                ld_val = ld_val | 32'hffff0000;
            st_mask = 32'hffff << shamt;
            st_word = b_reg << shamt;
        end
    end

    logic [2:0] addr_st;
    always_comb
    begin
        addr_st = ST_OK;
        if (ba[35] || ba > BYTE_ADDR_LIMIT || 36'(ba[35:2]) >= 36'(MEM_WORDS))
            addr_st = ST_RANGE;
        else if ((size_log == 2'd1 && ba[0]) || (size_log == 2'd2 && ba[1:0] != 2'd0))
            addr_st = ST_MISALIGN;
    end

    result_t r_exec;
    logic    illegal;
    logic [31:0] alu_b;
    always_comb
    begin
        illegal = 1'b0;
        alu_b   = b_reg;
        r_exec  = '0;
        unique case (opc)
            OPC_ALU_REG:
                illegal = !(f7 == 7'd0 || (f7 == F7_ALT && (f3 == 3'd0 || f3 == 3'd5)));
            OPC_ALU_IMM:
            begin
                alu_b = imm_i;
                if (f3 == 3'd1)
                    illegal = f7 != 7'd0;
                else if (f3 == 3'd5)
                    illegal = !(f7 == 7'd0 || f7 == F7_ALT);
            end
            OPC_LOAD:  illegal = (f3 == 3'd3) || (f3 > 3'd5);
            OPC_STORE: illegal = f3 > 3'd2;
            OPC_JALR:  illegal = f3 != 3'd0;
            default:   illegal = 1'b1;
        endcase
        r_exec.reg_dest  = rd;
        r_exec.reg_value = alu(f3, f7 == F7_ALT && (opc == OPC_ALU_REG || f3 == 3'd5),
                               a_reg, alu_b);
        if (opc == OPC_JALR)
            r_exec.reg_value = {19'd0, pc_reg[14:2]};
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: if (clr_reg == (AW+1)'(CLR_LEN - 1)) state_next = S_IDLE;
            S_IDLE:  if (in_valid) state_next = (op == OP_EXEC) ? S_FETCH : S_HOST;
            S_HOST:  state_next = S_OUT;
            S_FETCH: state_next = S_DEC;
            S_DEC:   state_next = S_EXEC;
            S_EXEC:  state_next = S_OUT;
            S_ADDR:  state_next = S_MEM;
            S_MEM:   state_next = S_OUT;
            S_OUT:   if (out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
        if (state_reg == S_FETCH && 32'(pc_reg[14:2]) >= 32'(MEM_WORDS))
            state_next = S_OUT;
        if (state_reg == S_EXEC && !illegal && (opc == OPC_LOAD || opc == OPC_STORE)
            && !(opc == OPC_LOAD && rd == 5'd0))
            state_next = S_ADDR;
    end

    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = AW'(addr_reg[13:2]);
        mem_wd = data_reg;
        if (state_reg == S_CLEAR)
        begin
            mem_we = 32'(clr_reg) < 32'(MEM_WORDS);
            mem_wa = clr_reg[AW-1:0];
            mem_wd = '0;
        end
        else if (state_reg == S_HOST && op_reg == OP_MEM_WRITE
                 && !host_bad_align && !host_bad_range)
            mem_we = 1'b1;
        else if (state_reg == S_MEM && opc == OPC_STORE && bst_reg == ST_OK)
        begin
            mem_we = 1'b1;
            mem_wa = AW'(ba_reg[35:2]);
            mem_wd = (mrd_reg & ~st_mask) | (st_word & st_mask);
        end
    end

    always_comb
    begin
        rf_we = 1'b0;
        rf_wa = rd;
        rf_wd = r_exec.reg_value;
        if (state_reg == S_CLEAR && 32'(clr_reg) < 32'd32)
        begin
            rf_we = 1'b1;
            rf_wa = clr_reg[4:0];
            rf_wd = '0;
        end
        else if (state_reg == S_EXEC && !illegal && rd != 5'd0 && opc != OPC_STORE
                 && opc != OPC_LOAD && !(opc == OPC_JALR && (jt[33] || 34'(jt) >= 34'(MEM_WORDS))))
            rf_we = 1'b1;
        else if (state_reg == S_MEM && opc == OPC_LOAD && bst_reg == ST_OK)
        begin
            rf_we = 1'b1;
            rf_wd = ld_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            pc_reg    <= '0;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
                clr_reg <= clr_reg + 1'b1;
            if (state_reg == S_IDLE && in_valid)
            begin
                op_reg   <= op;
                addr_reg <= address;
                data_reg <= data;
                res_reg  <= '0;
            end
            if (state_reg == S_HOST)
            begin
                if (op_reg == OP_REG_READ)
                    res_reg.read_data <= rrd_reg;
                else if (op_reg > OP_EXEC)
                    res_reg.status <= ST_ILLEGAL;
                else if (host_bad_align)
                    res_reg.status <= ST_MISALIGN;
                else if (host_bad_range)
                    res_reg.status <= ST_RANGE;
                else if (op_reg == OP_MEM_READ)
                    res_reg.read_data <= mrd_reg;
                else if (op_reg == OP_SET_PC)
                    pc_reg <= {1'b0, addr_reg};
            end
            if (state_reg == S_FETCH)
            begin
                if (32'(pc_reg[14:2]) >= 32'(MEM_WORDS))
                    res_reg.status <= ST_RANGE;
                else
                begin
                    ins_reg <= mrd_reg;
                    pc_reg  <= pc_reg + 15'd4;
                end
            end
            if (state_reg == S_EXEC)
            begin
                ba_reg  <= ba;
                bst_reg <= addr_st;
                if (illegal)
                    res_reg.status <= ST_ILLEGAL;
                else if (opc == OPC_STORE)
                begin
                    if (addr_st != ST_OK)
                        res_reg.status <= addr_st;
                end
                else if (rd == 5'd0)
                    res_reg.status <= ST_X0;
                else if (opc == OPC_LOAD)
                begin
                    if (addr_st != ST_OK)
                        res_reg.status <= addr_st;
                end
                else if (opc == OPC_JALR && (jt[33] || 34'(jt) >= 34'(MEM_WORDS)))
                    res_reg.status <= ST_RANGE;
                else
                begin
                    res_reg.reg_written <= 1'b1;
                    res_reg.reg_dest    <= rd;
                    res_reg.reg_value   <= r_exec.reg_value;
                    if (opc == OPC_JALR)
                        pc_reg <= {jt[12:0], 2'b00};
                end
            end
            if (state_reg == S_MEM && opc == OPC_LOAD && bst_reg == ST_OK)
            begin
                res_reg.reg_written <= 1'b1;
                res_reg.reg_dest    <= rd;
                res_reg.reg_value   <= ld_val;
            end
        end
    end

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = state_reg == S_OUT;
    assign res       = res_reg;
    assign pc        = pc_reg;

endmodule

/* sv/rv32i_subset_executor.sv */
// Top level of the RV32I subset executor.
// One transaction in, one result out. Host memory and register transactions
// pass the host state; an executed instruction passes fetch, register read
// and execute, and loads and stores that reach the address stage then pass
// the address and memory states, where stores read-modify-write the word
// memory; a fetch beyond memory goes straight to the result. The result is
// held until out_ready. After reset a clearing pass over MEM_WORDS entries
// (at least 32) zeroes memory and registers before the first transaction is taken.
module rv32i_subset_executor
    import rv32_pkg::*;
#(
    parameter int MEM_WORDS = MEM_WORDS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  op,
    input  logic [13:0] address,
    input  logic [4:0]  reg_index,
    input  logic [31:0] data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [31:0] read_data,
    output logic [14:0] pc_after,
    output logic        reg_written,
    output logic [4:0]  reg_dest,
    output logic [31:0] reg_value
);
    result_t res;

    rv32_core #(.MEM_WORDS(MEM_WORDS)) u_core (
        .clk, .rst_n, .in_valid, .in_ready, .op, .address, .reg_index, .data,
        .out_valid, .out_ready, .res, .pc(pc_after)
    );

    assign status      = res.status;
    assign read_data   = res.read_data;
    assign reg_written = res.reg_written;
    assign reg_dest    = res.reg_dest;
    assign reg_value   = res.reg_value;

endmodule
